### rtl/msgp_pkg.sv
// Shared constants, codes and pipeline item types of the multi-stop gradient pixel block.
`default_nettype none

package msgp_pkg;

   // Sizing of the stop store and the column span
   localparam int MAX_STOPS   = 16;
   localparam int MAX_COLUMNS = 4096;

   // Fixed field widths of the channels and registers
   localparam int OP_W        = 1;
   localparam int SIDX_FLD_W  = 4;
   localparam int COLOR_W     = 24;
   localparam int CHAN_W      = 8;
   localparam int COL_W       = 12;
   localparam int CFG_COLS_W  = 13;
   localparam int CFG_STOPS_W = 5;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_IDX_W   = 1;

   // Derived internal widths
   localparam int STOP_IDX_W = $clog2(MAX_STOPS);          // stop address, quotient of p / d
   localparam int D_W        = $clog2(MAX_COLUMNS);        // d = columns - 1
   localparam int P_W        = D_W + STOP_IDX_W;           // p = column * (stops - 1)
   localparam int N_W        = D_W + CHAN_W;               // blend numerator, below d * 256
   localparam int CMP_W      = (COL_W > D_W) ? COL_W : D_W;

   localparam logic [D_W-1:0]        D_MAX    = D_W'(MAX_COLUMNS - 1);
   localparam logic [STOP_IDX_W-1:0] LAST_MAX = STOP_IDX_W'(MAX_STOPS - 1);

   // Operation codes of an input beat
   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 1'b0,
      OP_RENDER = 1'b1
   } op_type;

   // Register indexes on the CSR port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_COLUMNS = 1'b0,
      CSR_NUM_STOPS   = 1'b1
   } csr_index_type;

   // Raw register values
   typedef struct packed {
      logic [CFG_COLS_W-1:0]  num_columns;
      logic [CFG_STOPS_W-1:0] num_stops;
   } cfg_type;

   // Item in the index divider (p / d)
   typedef struct packed {
      logic                    is_render;
      logic [SIDX_FLD_W-1:0]   stop_index;
      logic [COLOR_W-1:0]      stop_color;
      logic [COL_W-1:0]        col;
      logic [D_W-1:0]          div;
      logic [STOP_IDX_W-1:0]   last_stop;
      logic [P_W-1:0]          rem;
      logic [STOP_IDX_W-1:0]   quo;
   } idx_item_type;

   // Render item after the stop store read
   typedef struct packed {
      logic [COL_W-1:0]   col;
      logic [D_W-1:0]     div;
      logic [D_W-1:0]     rem;
      logic [COLOR_W-1:0] c1;
      logic [COLOR_W-1:0] c2;
   } mix_item_type;

endpackage

`default_nettype wire

### rtl/msgp_index_div.sv
// Front stage and restoring divider that split the column position into stop index and remainder.
`default_nettype none

module msgp_index_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire msgp_pkg::cfg_type                 cfg,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic [msgp_pkg::OP_W-1:0]         in_operation,
   input  wire logic [msgp_pkg::SIDX_FLD_W-1:0]   in_stop_index,
   input  wire logic [msgp_pkg::COLOR_W-1:0]      in_stop_color,
   input  wire logic [msgp_pkg::COL_W-1:0]        in_column,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output msgp_pkg::idx_item_type                 out_item
);

   localparam int NST  = msgp_pkg::STOP_IDX_W + 1;
   localparam int DW   = msgp_pkg::D_W;
   localparam int PW   = msgp_pkg::P_W;
   localparam int SW   = msgp_pkg::STOP_IDX_W;
   localparam int CW   = msgp_pkg::COL_W;
   localparam int CMPW = msgp_pkg::CMP_W;

   logic [NST-1:0]         valid_ff;
   msgp_pkg::idx_item_type stage_ff [NST];
   msgp_pkg::idx_item_type stage_in [NST];
   logic [NST-1:0]         stage_vin;
   logic [NST:0]           stage_ready;

   logic [DW-1:0]          d;
   logic [SW-1:0]          last;
   logic [CW-1:0]          col_sat;

   // Effective span and stop count from the raw registers
   always_comb begin
      if (cfg.num_columns == '0) begin
         d = '0;
      end else if (32'(cfg.num_columns) > 32'(msgp_pkg::MAX_COLUMNS)) begin
         d = msgp_pkg::D_MAX;
      end else begin
         d = DW'(cfg.num_columns - 1'b1);
      end
      if (cfg.num_stops == '0) begin
         last = '0;
      end else if (32'(cfg.num_stops) > 32'(msgp_pkg::MAX_STOPS)) begin
         last = msgp_pkg::LAST_MAX;
      end else begin
         last = SW'(cfg.num_stops - 1'b1);
      end
      col_sat = (CMPW'(in_column) > CMPW'(d)) ? CW'(d) : in_column;
   end

   // Stage 0: saturate column, form p; stages 1..: one quotient bit each
   always_comb begin
      msgp_pkg::idx_item_type item;
      logic [PW-1:0]          trial;
      stage_in[0]            = '0;
      stage_in[0].is_render  = (in_operation == msgp_pkg::OP_RENDER);
      stage_in[0].stop_index = in_stop_index;
      stage_in[0].stop_color = in_stop_color;
      stage_in[0].col        = col_sat;
      stage_in[0].div        = (d == '0) ? DW'(1) : d;   // single column: p is zero anyway
      stage_in[0].last_stop  = last;
      stage_in[0].rem        = PW'(col_sat) * PW'(last);
      stage_in[0].quo        = '0;
      stage_vin[0]           = in_valid;
      for (int k = 1; k < NST; k++) begin
         item  = stage_ff[k-1];
         trial = PW'(item.div) << (NST - 1 - k);
         if (item.rem >= trial) begin
            item.rem             = item.rem - trial;
            item.quo[NST - 1 - k] = 1'b1;
         end
         stage_in[k]  = item;
         stage_vin[k] = valid_ff[k-1];
      end
   end

   // Per-stage ready: a stage takes a beat when empty or draining
   always_comb begin
      stage_ready[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= stage_vin[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (stage_ready[k] && stage_vin[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[NST-1];
   assign out_item  = stage_ff[NST-1];

endmodule

`default_nettype wire

### rtl/msgp_stop_mem.sv
// Stop store stage: loads write a stop, renders read the two bracketing stops.
`default_nettype none

module msgp_stop_mem (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire msgp_pkg::idx_item_type in_item,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output msgp_pkg::mix_item_type      out_item
);

   localparam int SW = msgp_pkg::STOP_IDX_W;
   localparam int DW = msgp_pkg::D_W;

   logic [msgp_pkg::COLOR_W-1:0] stop_mem [msgp_pkg::MAX_STOPS];

   logic                   valid_ff;
   msgp_pkg::mix_item_type item_ff;
   logic                   accept;
   logic                   load_hit;
   logic [SW-1:0]          idx_lo;
   logic [SW-1:0]          idx_hi;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;
   assign load_hit = !in_item.is_render &&
                     (32'(in_item.stop_index) < 32'(msgp_pkg::MAX_STOPS));

   // Upper stop, clamped to the last one; a zero remainder needs only the lower stop
   always_comb begin
      idx_lo = in_item.quo;
      if (in_item.rem == '0 || in_item.quo == in_item.last_stop) begin
         idx_hi = in_item.quo;
      end else begin
         idx_hi = in_item.quo + 1'b1;
      end
   end

   // Store write and registered reads
   always_ff @(posedge clock) begin
      if (accept && load_hit) begin
         stop_mem[SW'(in_item.stop_index)] <= in_item.stop_color;
      end
      if (accept && in_item.is_render) begin
         item_ff.c1  <= stop_mem[idx_lo];
         item_ff.c2  <= stop_mem[idx_hi];
         item_ff.col <= in_item.col;
         item_ff.div <= in_item.div;
         item_ff.rem <= DW'(in_item.rem);
      end
   end

   // Loads end here; only renders move on
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid && in_item.is_render;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

### rtl/msgp_blend_div.sv
// Blend numerators per channel and pipelined restoring division by d, with the output register.
`default_nettype none

module msgp_blend_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire msgp_pkg::mix_item_type        in_item,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [msgp_pkg::COL_W-1:0]         out_column,
   output logic [msgp_pkg::CHAN_W-1:0]        out_red,
   output logic [msgp_pkg::CHAN_W-1:0]        out_green,
   output logic [msgp_pkg::CHAN_W-1:0]        out_blue
);

   localparam int HW  = msgp_pkg::CHAN_W;
   localparam int NW  = msgp_pkg::N_W;
   localparam int NST = HW + 1;

   typedef struct packed {
      logic [msgp_pkg::COL_W-1:0] col;
      logic [msgp_pkg::D_W-1:0]   div;
      logic [2:0][NW-1:0]         rem;
      logic [2:0][HW-1:0]         quo;
   } blend_stage_type;

   logic [NST-1:0]  valid_ff;
   blend_stage_type stage_ff [NST];
   blend_stage_type stage_in [NST];
   logic [NST-1:0]  stage_vin;
   logic [NST:0]    stage_ready;

   // Stage 0: (d-r)*c1 + r*c2; stages 1..: one quotient bit per channel
   always_comb begin
      blend_stage_type item;
      logic [HW-1:0]   a;
      logic [HW-1:0]   b;
      logic [NW-1:0]   prod_lo;
      logic [NW-1:0]   prod_hi;
      logic [NW-1:0]   trial;
      stage_in[0]     = '0;
      stage_in[0].col = in_item.col;
      stage_in[0].div = in_item.div;
      for (int ch = 0; ch < 3; ch++) begin
         a       = in_item.c1[HW*ch +: HW];
         b       = in_item.c2[HW*ch +: HW];
         prod_lo = NW'(in_item.div - in_item.rem) * NW'(a);
         prod_hi = NW'(in_item.rem) * NW'(b);
         stage_in[0].rem[ch] = prod_lo + prod_hi;
      end
      stage_vin[0] = in_valid;
      for (int k = 1; k < NST; k++) begin
         item  = stage_ff[k-1];
         trial = NW'(item.div) << (NST - 1 - k);
         for (int ch = 0; ch < 3; ch++) begin
            if (item.rem[ch] >= trial) begin
               item.rem[ch]              = item.rem[ch] - trial;
               item.quo[ch][NST - 1 - k] = 1'b1;
            end
         end
         stage_in[k]  = item;
         stage_vin[k] = valid_ff[k-1];
      end
   end

   // Per-stage ready chain back from the result port
   always_comb begin
      stage_ready[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= stage_vin[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (stage_ready[k] && stage_vin[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // Last stage is the output register; channel 2 is red, 0 is blue
   assign in_ready   = stage_ready[0];
   assign out_valid  = valid_ff[NST-1];
   assign out_column = stage_ff[NST-1].col;
   assign out_red    = stage_ff[NST-1].quo[2];
   assign out_green  = stage_ff[NST-1].quo[1];
   assign out_blue   = stage_ff[NST-1].quo[0];

endmodule

`default_nettype wire

### rtl/multi_stop_gradient_pixel.sv
// Top level of the multi-stop linear gradient pixel generator: CSR block and pipeline chain.
`default_nettype none

// Linear multi-stop color gradient, one beat per clock in and one pixel per clock out while rsp_stall is low.
// Load beats (operation 0) write a 0xRRGGBB stop into a 16-entry stop store; they take
// effect in stream order and give no result. Render beats (operation 1) give one pixel
// for the column, saturated to num_columns-1, with each channel the exact truncated
// blend ((d-r)*c[i] + r*c[i+1]) / d of the two bracketing stops, d = num_columns-1.
// A span of one column returns stop 0. From accepted beat to pixel there are a front
// stage and 4 restoring-division stages for the stop index, one stop store read stage,
// a multiply stage and 8 division stages per channel, the last of which is the output
// register. Each stage moves on its own, so bubbles close up while the result side
// stalls. Write num_columns and num_stops only with the pipeline empty; stops must be
// loaded before any render reads them.
module multi_stop_gradient_pixel (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [msgp_pkg::OP_W-1:0]           req_operation,
   input  wire logic [msgp_pkg::SIDX_FLD_W-1:0]     req_stop_index,
   input  wire logic [msgp_pkg::COLOR_W-1:0]        req_stop_color,
   input  wire logic [msgp_pkg::COL_W-1:0]          req_column,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [msgp_pkg::COL_W-1:0]               rsp_column_out,
   output logic [msgp_pkg::CHAN_W-1:0]              rsp_red,
   output logic [msgp_pkg::CHAN_W-1:0]              rsp_green,
   output logic [msgp_pkg::CHAN_W-1:0]              rsp_blue,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [msgp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [msgp_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [msgp_pkg::CFG_COLS_W-1:0]  num_columns_ff;
   logic [msgp_pkg::CFG_STOPS_W-1:0] num_stops_ff;
   msgp_pkg::cfg_type                cfg;

   logic                   in_ready;
   logic                   idx_valid;
   logic                   idx_ready;
   msgp_pkg::idx_item_type idx_item;
   logic                   mix_valid;
   logic                   mix_ready;
   msgp_pkg::mix_item_type mix_item;

   // CSR writes, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_columns_ff <= msgp_pkg::CFG_COLS_W'(120);
         num_stops_ff   <= msgp_pkg::CFG_STOPS_W'(2);
      end else if (csr_valid && csr_ready) begin
         unique case (msgp_pkg::csr_index_type'(csr_index))
            msgp_pkg::CSR_NUM_COLUMNS: begin
               num_columns_ff <= msgp_pkg::CFG_COLS_W'(csr_data);
            end
            msgp_pkg::CSR_NUM_STOPS: begin
               num_stops_ff <= msgp_pkg::CFG_STOPS_W'(csr_data);
            end
         endcase
      end
   end

   assign cfg.num_columns = num_columns_ff;
   assign cfg.num_stops   = num_stops_ff;

   // Stop index and remainder
   msgp_index_div u_index_div (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .in_valid      (req_valid),
      .in_ready      (in_ready),
      .in_operation  (req_operation),
      .in_stop_index (req_stop_index),
      .in_stop_color (req_stop_color),
      .in_column     (req_column),
      .out_valid     (idx_valid),
      .out_ready     (idx_ready),
      .out_item      (idx_item)
   );

   assign req_stall = !in_ready;

   // Stop store
   msgp_stop_mem u_stop_mem (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (idx_valid),
      .in_ready  (idx_ready),
      .in_item   (idx_item),
      .out_valid (mix_valid),
      .out_ready (mix_ready),
      .out_item  (mix_item)
   );

   // Channel blend and output register
   msgp_blend_div u_blend_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mix_valid),
      .in_ready   (mix_ready),
      .in_item    (mix_item),
      .out_valid  (rsp_valid),
      .out_ready  (!rsp_stall),
      .out_column (rsp_column_out),
      .out_red    (rsp_red),
      .out_green  (rsp_green),
      .out_blue   (rsp_blue)
   );

`ifndef SYNTHESIS
   // Stop index never passes the last stop in use
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      idx_valid |-> (idx_item.quo <= idx_item.last_stop))
      else $error("stop index beyond last stop");

   // Remainder left by the index divider is below the divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (idx_valid && idx_item.is_render) |->
         (idx_item.rem < msgp_pkg::P_W'(idx_item.div)))
      else $error("index remainder not below divisor");

   // Pipeline is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
